FILE: rtl/tpc_pkg.sv
// Shared constants and types for the triangle plane clipper.
// Used by every module of the block; depends on nothing else.
package tpc_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int COORD_BITS_DEF = 32;
  localparam int PLANE_W        = 32;
  localparam int MARGIN_W       = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  // Raw quotient width and saturated interpolation factor width.
  localparam int QUO_W          = 64;
  localparam int TQ_W           = 63;
  localparam int MUL_LO_W       = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PLANE_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN  = 3'd4;

  localparam logic [PLANE_W-1:0]  PLANE_A_RST = 32'h0001_0000;
  localparam logic [PLANE_W-1:0]  PLANE_B_RST = 32'h0000_0000;
  localparam logic [PLANE_W-1:0]  PLANE_C_RST = 32'h0000_0000;
  localparam logic [PLANE_W-1:0]  PLANE_D_RST = 32'h0001_0000;
  localparam logic [MARGIN_W-1:0] MARGIN_RST  = 16'd1;

  typedef struct packed {
    logic full;
    logic empty;
  } tpc_qstat_t;

endpackage

FILE: rtl/tpc_front.sv
// Front end: accepts a triangle, computes the three plane distances and
// the inside flags, and pushes the classified item into the queue. Uses tpc_pkg.
module tpc_front import tpc_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int PW        = PLANE_W + COORD_BITS,
  localparam int DW        = PW + 2,
  localparam int ENT_W     = 3 + 3 * DW + 12 * COORD_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [11:0][COORD_BITS-1:0]      vin,
  input  logic [3:0][PLANE_W-1:0]          plane_coef,
  input  logic [MARGIN_W-1:0]              margin,
  input  tpc_qstat_t                       qstat,
  output logic                             push,
  output logic [ENT_W-1:0]                 push_data
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t state;
  logic [1:0] cnt;
  logic [11:0][COORD_BITS-1:0] verts;
  logic signed [PW-1:0] prod [3];
  logic signed [DW-1:0] acc [3];
  logic signed [DW-1:0] pdist [3];
  logic [2:0] ins;
  logic accept;

  assign busy   = !(state == F_IDLE || (state == F_PUSH && !qstat.full));
  assign accept = start && !busy;
  assign push   = (state == F_PUSH) && !qstat.full;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    logic signed [DW:0] biased;
    always_ff @(posedge clk) begin
      if (state == F_MUL) begin
        prod[g] <= $signed(plane_coef[cnt]) * $signed(verts[{2'(g), cnt}]);
        if (cnt == 2'd0) begin
          acc[g] <= '0;
        end else begin
          acc[g] <= acc[g] + DW'(prod[g]);
        end
      end
    end
    assign pdist[g] = acc[g] + DW'(prod[g]);
    // Inside when the distance is no lower than minus the margin.
    assign biased  = (DW + 1)'(pdist[g]) +
                     $signed({1'b0, (DW)'({margin, {FRAC_BITS{1'b0}}})});
    assign ins[g]  = !biased[DW];
  end

  assign push_data = {ins, pdist[2], pdist[1], pdist[0], verts};

  always_ff @(posedge clk) begin
    if (accept) begin
      verts <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            state <= F_MUL;
            cnt   <= '0;
          end
        end
        F_MUL: begin
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!qstat.full) begin
            cnt   <= '0;
            state <= accept ? F_MUL : F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/tpc_queue.sv
// Two-entry queue that decouples classification from clipping.
// Uses tpc_pkg for the status struct.
module tpc_queue import tpc_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output tpc_qstat_t   qstat
);

  logic [W-1:0] slots [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;

  assign qstat.full  = (count == 2'd2);
  assign qstat.empty = (count == 2'd0);
  assign pop_data    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: rtl/tpc_back.sv
// Back end: walks the edges of a queued triangle, runs the serial divider
// and the split multiplier for crossings, and drives the result register.
// Uses tpc_pkg.
module tpc_back import tpc_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int PW        = PLANE_W + COORD_BITS,
  localparam int DW        = PW + 2,
  localparam int ENT_W     = 3 + 3 * DW + 12 * COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [ENT_W-1:0]             entry,
  input  tpc_qstat_t                   qstat,
  output logic                         pop,
  output logic                         res_valid,
  output logic [3:0][COORD_BITS-1:0]   res_coord,
  output logic                         res_last,
  output logic                         res_culled,
  output logic                         res_unchanged
);

  localparam int C     = COORD_BITS;
  localparam int DNW   = DW + 1;
  localparam int NUMW  = DW + FRAC_BITS;
  localparam int HI_W  = TQ_W - MUL_LO_W;
  localparam int DFW   = C + 1;
  localparam int PRODW = DFW + TQ_W;
  localparam int SPW   = PRODW + 1;
  localparam int SW    = SPW + 1;
  localparam logic [TQ_W-1:0] T_LIM = {1'b1, {(TQ_W-1){1'b0}}};
  localparam logic signed [SW-1:0] C_MAX = {{(SW-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [SW-1:0] C_MIN = {{(SW-C+1){1'b1}}, {(C-1){1'b0}}};

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_EDGE  = 5'b00010,
    B_DIV   = 5'b00100,
    B_SCALE = 5'b01000,
    B_MUL   = 5'b10000
  } bstate_t;

  bstate_t state;

  logic [11:0][C-1:0] verts;
  logic signed [DW-1:0] pdist [3];
  logic [2:0] ins;
  logic [2:0] total;
  logic [2:0] nsent;
  logic [1:0] eidx, pidx, mk, ph;
  logic xdone;

  assign verts   = entry[12*C-1:0];
  assign ins     = entry[ENT_W-1 -: 3];
  for (genvar g = 0; g < 3; g++) begin : g_pdist
    assign pdist[g] = entry[12*C + g*DW +: DW];
  end

  // Mixed triangles emit two crossings besides their inside vertices.
  assign total = 3'(ins[0]) + 3'(ins[1]) + 3'(ins[2]) +
                 ((ins != 3'b000 && ins != 3'b111) ? 3'd2 : 3'd0);
  assign pidx  = (eidx == 2'd0) ? 2'd2 : eidx - 2'd1;

  // Divider setup from the distances at both ends of the edge.
  logic signed [DW-1:0]  dp, dc;
  logic signed [DNW-1:0] den_s;
  logic signed [NUMW-1:0] num_s;
  logic [DNW-1:0]  den_abs;
  logic [NUMW-1:0] num_abs, rem_init;
  logic xing;

  assign dp      = pdist[pidx];
  assign dc      = pdist[eidx];
  assign den_s   = DNW'(dp) - DNW'(dc);
  assign num_s   = $signed({dp, {FRAC_BITS{1'b0}}});
  assign den_abs = den_s[DNW-1] ? DNW'(-den_s) : DNW'(den_s);
  assign num_abs = num_s[NUMW-1] ? NUMW'(-num_s) : NUMW'(num_s);
  assign rem_init = num_abs >> QUO_W;
  assign xing    = (ins[eidx] != ins[pidx]) && !xdone;

  // Divider registers.
  logic [DNW-1:0]   den_mag, rem;
  logic [QUO_W-1:0] nlow, quo;
  logic [5:0]       dcnt;
  logic             ovf, tneg;
  logic [DNW:0]     trial;
  logic [TQ_W-1:0]  tqm;

  assign trial = {rem, nlow[QUO_W-1]};

  // Split multiplier for one coordinate.
  logic signed [C-1:0]   pc, cc;
  logic signed [DFW-1:0] diff;
  logic [DFW-1:0]        dmag;
  logic [DFW+MUL_LO_W-1:0] plo;
  logic [DFW+HI_W-1:0]   phi;
  logic [PRODW-1:0]      full;
  logic signed [SPW-1:0] sp, shv;
  logic signed [SW-1:0]  sum, sumreg;
  logic [C-1:0]          sat;
  logic [2:0][C-1:0]     xbuf;

  assign pc   = verts[{pidx, mk}];
  assign cc   = verts[{eidx, mk}];
  assign diff = DFW'(cc) - DFW'(pc);
  assign dmag = diff[DFW-1] ? DFW'(-diff) : DFW'(diff);
  assign full = PRODW'(plo) + (PRODW'(phi) << MUL_LO_W);
  assign sp   = (diff[DFW-1] ^ tneg) ? -$signed({1'b0, full}) : $signed({1'b0, full});
  assign shv  = sp >>> FRAC_BITS;
  assign sum  = SW'(pc) + SW'(shv);

  always_comb begin
    if (sumreg > C_MAX) begin
      sat = C_MAX[C-1:0];
    end else if (sumreg < C_MIN) begin
      sat = C_MIN[C-1:0];
    end else begin
      sat = sumreg[C-1:0];
    end
  end

  always_comb begin
    pop = 1'b0;
    case (state)
      B_IDLE: pop = !qstat.empty && (ins == 3'b000);
      B_EDGE: pop = !xing && (eidx == 2'd2);
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      B_EDGE: begin
        den_mag <= den_abs;
        rem     <= DNW'(rem_init);
        nlow    <= QUO_W'(num_abs);
        ovf     <= (rem_init >= NUMW'(den_abs));
        tneg    <= dp[DW-1] ^ den_s[DNW-1];
        quo     <= '0;
      end
      B_DIV: begin
        if (trial >= (DNW + 1)'(den_mag)) begin
          rem <= DNW'(trial - (DNW + 1)'(den_mag));
          quo <= {quo[QUO_W-2:0], 1'b1};
        end else begin
          rem <= DNW'(trial);
          quo <= {quo[QUO_W-2:0], 1'b0};
        end
        nlow <= {nlow[QUO_W-2:0], 1'b0};
      end
      B_SCALE: begin
        tqm <= (ovf || quo > {1'b0, T_LIM}) ? T_LIM : quo[TQ_W-1:0];
      end
      B_MUL: begin
        case (ph)
          2'd0: plo <= dmag * tqm[MUL_LO_W-1:0];
          2'd1: phi <= dmag * tqm[TQ_W-1:MUL_LO_W];
          2'd2: sumreg <= sum;
          default: if (mk != 2'd3) xbuf[mk] <= sat;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      res_valid <= 1'b0;
      eidx      <= '0;
      xdone     <= 1'b0;
      nsent     <= '0;
      dcnt      <= '0;
      mk        <= '0;
      ph        <= '0;
    end else begin
      res_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (!qstat.empty) begin
            if (ins == 3'b000) begin
              res_valid     <= 1'b1;
              res_coord     <= '0;
              res_last      <= 1'b1;
              res_culled    <= 1'b1;
              res_unchanged <= 1'b0;
            end else begin
              state <= B_EDGE;
              eidx  <= '0;
              xdone <= 1'b0;
              nsent <= '0;
            end
          end
        end
        B_EDGE: begin
          if (xing) begin
            state <= B_DIV;
            dcnt  <= '0;
          end else begin
            if (ins[eidx]) begin
              res_valid     <= 1'b1;
              res_coord     <= {verts[{eidx, 2'd3}], verts[{eidx, 2'd2}],
                                verts[{eidx, 2'd1}], verts[{eidx, 2'd0}]};
              res_last      <= (nsent == total - 3'd1);
              res_culled    <= 1'b0;
              res_unchanged <= (ins == 3'b111);
              nsent         <= nsent + 3'd1;
            end
            xdone <= 1'b0;
            if (eidx == 2'd2) begin
              state <= B_IDLE;
            end else begin
              eidx <= eidx + 2'd1;
            end
          end
        end
        B_DIV: begin
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'(QUO_W - 1)) begin
            state <= B_SCALE;
          end
        end
        B_SCALE: begin
          state <= B_MUL;
          mk    <= '0;
          ph    <= '0;
        end
        B_MUL: begin
          ph <= ph + 2'd1;
          if (ph == 2'd3) begin
            mk <= mk + 2'd1;
            if (mk == 2'd3) begin
              res_valid     <= 1'b1;
              res_coord     <= {sat, xbuf[2], xbuf[1], xbuf[0]};
              res_last      <= (nsent == total - 3'd1);
              res_culled    <= 1'b0;
              res_unchanged <= 1'b0;
              nsent         <= nsent + 3'd1;
              xdone         <= 1'b1;
              state         <= B_EDGE;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_cull_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_culled |-> res_last) else $error("culled result not last");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_culled && res_unchanged)) else $error("culled and unchanged");
  a_pop: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty) else $error("pop from empty queue");
  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    state == B_DIV |=> state == B_DIV || state == B_SCALE) else $error("divider left early");

endmodule

FILE: rtl/triangle_plane_clipper_unit.sv
// Top level of the single-plane triangle clipper.
// Instantiates tpc_front, tpc_queue and tpc_back; uses tpc_pkg.
//
// A triangle is taken when start is high and busy is low. The front end
// forms the plane distances (one multiplier per vertex, one coefficient a
// cycle) and then hands the item to a two-entry queue, waiting while the
// queue is full; a new triangle can be taken in the cycle that the last is
// pushed, so the front end goes on while the back end works. A fully
// culled triangle gives the back end a single result; an untouched one
// gives its three results. Each edge crossing runs through setup of the
// bit-serial divider, the divider forming the interpolation factor, a step
// saturating it, and the four coordinates through the split multiplier.
// Results appear on out_x..out_w
// with last, culled and unchanged for exactly one cycle while out_valid is
// high; they cannot be held off, so the receiver must take every one.
// Configuration writes are always ready and must only be made while no
// triangle is in flight.
module triangle_plane_clipper_unit import tpc_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] v0_x,
  input  logic signed [COORD_BITS-1:0] v0_y,
  input  logic signed [COORD_BITS-1:0] v0_z,
  input  logic signed [COORD_BITS-1:0] v0_w,
  input  logic signed [COORD_BITS-1:0] v1_x,
  input  logic signed [COORD_BITS-1:0] v1_y,
  input  logic signed [COORD_BITS-1:0] v1_z,
  input  logic signed [COORD_BITS-1:0] v1_w,
  input  logic signed [COORD_BITS-1:0] v2_x,
  input  logic signed [COORD_BITS-1:0] v2_y,
  input  logic signed [COORD_BITS-1:0] v2_z,
  input  logic signed [COORD_BITS-1:0] v2_w,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  output logic                         out_valid,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic signed [COORD_BITS-1:0] out_z,
  output logic signed [COORD_BITS-1:0] out_w,
  output logic                         last,
  output logic                         culled,
  output logic                         unchanged
);

  localparam int PW    = PLANE_W + COORD_BITS;
  localparam int DW    = PW + 2;
  localparam int ENT_W = 3 + 3 * DW + 12 * COORD_BITS;

  // Plane registers; a write to an index past the margin is dropped.
  logic [3:0][PLANE_W-1:0] plane_coef;
  logic [MARGIN_W-1:0]     margin;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_coef <= {PLANE_D_RST, PLANE_C_RST, PLANE_B_RST, PLANE_A_RST};
      margin     <= MARGIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PLANE_A: plane_coef[0] <= cfg_data[PLANE_W-1:0];
        REG_PLANE_B: plane_coef[1] <= cfg_data[PLANE_W-1:0];
        REG_PLANE_C: plane_coef[2] <= cfg_data[PLANE_W-1:0];
        REG_PLANE_D: plane_coef[3] <= cfg_data[PLANE_W-1:0];
        REG_MARGIN:  margin        <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  logic [11:0][COORD_BITS-1:0] vin;
  assign vin = {v2_w, v2_z, v2_y, v2_x, v1_w, v1_z, v1_y, v1_x,
                v0_w, v0_z, v0_y, v0_x};

  tpc_qstat_t         qstat;
  logic               push, pop;
  logic [ENT_W-1:0]   push_data, pop_data;
  logic [3:0][COORD_BITS-1:0] res_coord;

  tpc_front #(.FRAC_BITS(FRAC_BITS), .COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .vin(vin),
    .plane_coef(plane_coef), .margin(margin), .qstat(qstat),
    .push(push), .push_data(push_data)
  );

  tpc_queue #(.W(ENT_W)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data),
    .pop(pop), .pop_data(pop_data), .qstat(qstat)
  );

  tpc_back #(.FRAC_BITS(FRAC_BITS), .COORD_BITS(COORD_BITS)) u_back (
    .clk(clk), .rst(rst), .entry(pop_data), .qstat(qstat), .pop(pop),
    .res_valid(out_valid), .res_coord(res_coord), .res_last(last),
    .res_culled(culled), .res_unchanged(unchanged)
  );

  assign out_x = res_coord[0];
  assign out_y = res_coord[1];
  assign out_z = res_coord[2];
  assign out_w = res_coord[3];

endmodule
